/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// shared property checks for the path smoother
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLY(name, clk, rstn, a, b) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (a) |-> (b)) \
        else $error("same-cycle check failed");
`define ASSERT_NEXT(name, clk, rstn, a, b) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (a) |=> (b)) \
        else $error("next-cycle check failed");
`else
`define ASSERT_IMPLY(name, clk, rstn, a, b)
`define ASSERT_NEXT(name, clk, rstn, a, b)
`endif
`endif

/* rtl/crps_pkg.sv */
// ----------------------------------------------------------------------------
// crps_pkg
// shared types and constants of the catmull-rom path smoother
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package crps_pkg;

    localparam int COORD_W    = 16;
    localparam int WEIGHT_W   = 16;
    localparam int W_ONE      = 16384;
    localparam int FIFO_DEPTH = 4;

    typedef struct packed {
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } xy_t;

    typedef struct packed {
        logic smooth;
        logic has;
        xy_t  pos;
    } wpt_t;

    // one segment or end point for the sample engine
    typedef struct packed {
        xy_t  p0;
        xy_t  p1;
        xy_t  p2;
        xy_t  p3;
        logic curved;
        logic run_last;
        logic path_end;
    } cmd_t;

endpackage

/* rtl/crps_front.sv */
// ----------------------------------------------------------------------------
// crps_front
// accepts control points, keeps the point window and issues segment commands
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crps_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [31:0]        s_tdata,   // point_x, point_y
    input  logic [1:0]         s_tuser,   // has_flag, smooth_flag
    input  logic               s_tlast,
    output logic               cmd_valid,
    input  logic               cmd_ready,
    output crps_pkg::cmd_t     cmd_data
);

    crps_pkg::wpt_t win_reg  [3];
    crps_pkg::wpt_t win_next [3];
    logic [1:0]     seen_reg, seen_next;
    crps_pkg::cmd_t pend_reg  [3];
    crps_pkg::cmd_t pend_next [3];
    logic [2:0]     mask_reg, mask_next;

    crps_pkg::wpt_t cur;
    crps_pkg::cmd_t cand [3];
    logic [2:0]     cand_v;
    crps_pkg::cmd_t list [3];
    logic [1:0]     n;
    logic [2:0]     list_mask;
    logic           accept;
    logic           push;

    function automatic logic is_curved(crps_pkg::wpt_t a, crps_pkg::wpt_t b);
        logic c;
        if (a.has) begin
            c = a.smooth;
        end else begin
            c = (a.pos.x != b.pos.x) && (a.pos.y != b.pos.y);
        end
        return c;
    endfunction

    assign s_tready  = (mask_reg == 3'b000);
    assign accept    = s_tvalid && s_tready;
    assign cmd_valid = mask_reg[0];
    assign cmd_data  = pend_reg[0];
    assign push      = mask_reg[0] && cmd_ready;

    always_comb begin
        cur.pos.x  = s_tdata[15:0];
        cur.pos.y  = s_tdata[31:16];
        cur.has    = s_tuser[0];
        cur.smooth = s_tuser[1];

        // segment from the middle point to the newest one
        cand[0].p0       = (seen_reg == 2'd3) ? win_reg[2].pos : win_reg[1].pos;
        cand[0].p1       = win_reg[1].pos;
        cand[0].p2       = win_reg[0].pos;
        cand[0].p3       = cur.pos;
        cand[0].curved   = is_curved(win_reg[1], win_reg[0]);
        cand[0].run_last = 1'b0;
        cand[0].path_end = 1'b0;
        cand_v[0]        = (seen_reg >= 2'd2);

        // closing segment into the last point
        cand[1].p0       = (seen_reg >= 2'd2) ? win_reg[1].pos : win_reg[0].pos;
        cand[1].p1       = win_reg[0].pos;
        cand[1].p2       = cur.pos;
        cand[1].p3       = cur.pos;
        cand[1].curved   = is_curved(win_reg[0], cur);
        cand[1].run_last = 1'b0;
        cand[1].path_end = 1'b0;
        cand_v[1]        = s_tlast && (seen_reg >= 2'd1);

        // the last point itself
        cand[2].p0       = cur.pos;
        cand[2].p1       = cur.pos;
        cand[2].p2       = cur.pos;
        cand[2].p3       = cur.pos;
        cand[2].curved   = 1'b0;
        cand[2].run_last = 1'b0;
        cand[2].path_end = 1'b1;
        cand_v[2]        = s_tlast;

        list = cand;
        n    = 2'd0;
        for (int i = 0; i < 3; i++) begin
            if (cand_v[i]) begin
                list[n] = cand[i];
                n       = n + 2'd1;
            end
        end
        if (n != 2'd0) begin
            list[n - 2'd1].run_last = 1'b1;
        end

        case (n)
            2'd0:    list_mask = 3'b000;
            2'd1:    list_mask = 3'b001;
            2'd2:    list_mask = 3'b011;
            default: list_mask = 3'b111;
        endcase
    end

    always_comb begin
        win_next  = win_reg;
        seen_next = seen_reg;
        pend_next = pend_reg;
        mask_next = mask_reg;
        if (accept) begin
            pend_next = list;
            mask_next = list_mask;
            if (s_tlast) begin
                win_next[0] = '0;
                win_next[1] = '0;
                win_next[2] = '0;
                seen_next   = 2'd0;
            end else begin
                win_next[2] = win_reg[1];
                win_next[1] = win_reg[0];
                win_next[0] = cur;
                if (seen_reg != 2'd3) begin
                    seen_next = seen_reg + 2'd1;
                end
            end
        end else if (push) begin
            pend_next[0] = pend_reg[1];
            pend_next[1] = pend_reg[2];
            mask_next    = {1'b0, mask_reg[2:1]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg[0] <= '0;
            win_reg[1] <= '0;
            win_reg[2] <= '0;
            seen_reg   <= 2'd0;
            mask_reg   <= 3'b000;
        end else begin
            win_reg  <= win_next;
            seen_reg <= seen_next;
            mask_reg <= mask_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_reg <= pend_next;
    end

endmodule

/* rtl/crps_fifo.sv */
// ----------------------------------------------------------------------------
// crps_fifo
// short command queue between the front end and the sample engine
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crps_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  crps_pkg::cmd_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output crps_pkg::cmd_t out_data
);

    localparam int AW = $clog2(crps_pkg::FIFO_DEPTH);

    crps_pkg::cmd_t slot_reg [crps_pkg::FIFO_DEPTH];
    logic [AW-1:0]  wr_reg, rd_reg;
    logic [AW:0]    cnt_reg;
    logic           wr_en;
    logic           rd_en;

    assign in_ready  = (cnt_reg != (AW+1)'(crps_pkg::FIFO_DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign out_data  = slot_reg[rd_reg];
    assign wr_en     = in_valid && in_ready;
    assign rd_en     = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (wr_en) begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (rd_en) begin
                rd_reg <= rd_reg + 1'b1;
            end
            if (wr_en && !rd_en) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (rd_en && !wr_en) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            slot_reg[wr_reg] <= in_data;
        end
    end

endmodule

/* rtl/crps_back.sv */
// ----------------------------------------------------------------------------
// crps_back
// sample engine: walks each command and runs the weighted sum pipeline
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crps_back #(
    parameter int SAMPLES = 20
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cmd_valid,
    output logic           cmd_ready,
    input  crps_pkg::cmd_t cmd_data,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [31:0]    m_tdata,   // out_x, out_y
    output logic           m_tlast,
    output logic [0:0]     m_tuser    // path_end
);

    localparam int     KW   = $clog2(SAMPLES);
    localparam int     WW   = crps_pkg::WEIGHT_W;
    localparam int     CW   = crps_pkg::COORD_W;
    localparam longint NS   = SAMPLES;
    localparam longint N3   = NS * NS * NS;
    localparam longint DEN  = 2 * N3;
    localparam longint ONE  = crps_pkg::W_ONE;

    function automatic longint wnum(int j, longint k, longint n);
        longint num;
        case (j)
            0:       num = -k * n * n + 2 * k * k * n - k * k * k;
            1:       num = 2 * n * n * n - 5 * k * k * n + 3 * k * k * k;
            2:       num = k * n * n + 4 * k * k * n - 3 * k * k * k;
            default: num = -k * k * n + k * k * k;
        endcase
        return num;
    endfunction

    function automatic logic [CW-1:0] round_sat(logic signed [2*CW+1:0] s);
        logic signed [2*CW+2:0] t;
        logic signed [20:0]     r;
        logic [CW-1:0]          o;
        t = (2*CW+3)'(s) + (2*CW+3)'(8192);
        r = 21'(t >>> 14);
        if (r > 21'sd32767) begin
            o = 16'h7fff;
        end else if (r < -21'sd32768) begin
            o = 16'h8000;
        end else begin
            o = r[CW-1:0];
        end
        return o;
    endfunction

    // q2.14 weight table, one row per sample
    logic signed [WW-1:0] wtab [SAMPLES][4];

    for (genvar k = 0; k < SAMPLES; k++) begin : g_wrow
        localparam longint K  = k;
        localparam longint W0 = (wnum(0, K, NS) * ONE + N3 + 4 * ONE * DEN) / DEN - 4 * ONE;
        localparam longint W1 = (wnum(1, K, NS) * ONE + N3 + 4 * ONE * DEN) / DEN - 4 * ONE;
        localparam longint W2 = (wnum(2, K, NS) * ONE + N3 + 4 * ONE * DEN) / DEN - 4 * ONE;
        localparam longint W3 = (wnum(3, K, NS) * ONE + N3 + 4 * ONE * DEN) / DEN - 4 * ONE;
        assign wtab[k][0] = WW'(W0);
        assign wtab[k][1] = WW'(W1);
        assign wtab[k][2] = WW'(W2);
        assign wtab[k][3] = WW'(W3);
    end

    logic           cur_valid_reg;
    crps_pkg::cmd_t cur_reg;
    logic [KW-1:0]  k_reg;
    logic [KW-1:0]  k_last;
    logic           adv;
    logic           issue;
    logic           done;
    logic           pop;

    logic signed [WW-1:0]   s0_w_reg [4];
    logic signed [CW-1:0]   s0_x_reg [4];
    logic signed [CW-1:0]   s0_y_reg [4];
    logic                   s0_valid_reg, s0_last_reg, s0_end_reg;
    logic signed [2*CW-1:0] s1_px_reg [4];
    logic signed [2*CW-1:0] s1_py_reg [4];
    logic                   s1_valid_reg, s1_last_reg, s1_end_reg;
    logic signed [2*CW:0]   s2_sx_reg [2];
    logic signed [2*CW:0]   s2_sy_reg [2];
    logic                   s2_valid_reg, s2_last_reg, s2_end_reg;
    logic                   m_tvalid_reg;
    logic [31:0]            m_tdata_reg;
    logic                   m_tlast_reg;
    logic                   m_tuser_reg;

    logic signed [2*CW+1:0] sum_x;
    logic signed [2*CW+1:0] sum_y;

    assign adv       = !(m_tvalid_reg && !m_tready);
    assign k_last    = cur_reg.curved ? KW'(SAMPLES - 1) : '0;
    assign issue     = cur_valid_reg && adv;
    assign done      = issue && (k_reg == k_last);
    assign cmd_ready = !cur_valid_reg || done;
    assign pop       = cmd_valid && cmd_ready;

    assign sum_x = (2*CW+2)'(s2_sx_reg[0]) + (2*CW+2)'(s2_sx_reg[1]);
    assign sum_y = (2*CW+2)'(s2_sy_reg[0]) + (2*CW+2)'(s2_sy_reg[1]);

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tlast    = m_tlast_reg;
    assign m_tuser[0] = m_tuser_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            k_reg         <= '0;
            s0_valid_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (pop) begin
                cur_valid_reg <= 1'b1;
                k_reg         <= '0;
            end else if (done) begin
                cur_valid_reg <= 1'b0;
            end else if (issue) begin
                k_reg <= k_reg + 1'b1;
            end
            if (adv) begin
                s0_valid_reg <= issue;
                s1_valid_reg <= s0_valid_reg;
                s2_valid_reg <= s1_valid_reg;
                m_tvalid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            cur_reg <= cmd_data;
        end
        if (adv) begin
            if (cur_reg.curved) begin
                s0_w_reg <= wtab[k_reg];
            end else begin
                s0_w_reg[0] <= '0;
                s0_w_reg[1] <= WW'(crps_pkg::W_ONE);
                s0_w_reg[2] <= '0;
                s0_w_reg[3] <= '0;
            end
            s0_x_reg[0] <= cur_reg.p0.x;
            s0_x_reg[1] <= cur_reg.p1.x;
            s0_x_reg[2] <= cur_reg.p2.x;
            s0_x_reg[3] <= cur_reg.p3.x;
            s0_y_reg[0] <= cur_reg.p0.y;
            s0_y_reg[1] <= cur_reg.p1.y;
            s0_y_reg[2] <= cur_reg.p2.y;
            s0_y_reg[3] <= cur_reg.p3.y;
            s0_last_reg <= done && cur_reg.run_last;
            s0_end_reg  <= done && cur_reg.path_end;

            for (int i = 0; i < 4; i++) begin
                s1_px_reg[i] <= s0_w_reg[i] * s0_x_reg[i];
                s1_py_reg[i] <= s0_w_reg[i] * s0_y_reg[i];
            end
            s1_last_reg <= s0_last_reg;
            s1_end_reg  <= s0_end_reg;

            s2_sx_reg[0] <= (2*CW+1)'(s1_px_reg[0]) + (2*CW+1)'(s1_px_reg[1]);
            s2_sx_reg[1] <= (2*CW+1)'(s1_px_reg[2]) + (2*CW+1)'(s1_px_reg[3]);
            s2_sy_reg[0] <= (2*CW+1)'(s1_py_reg[0]) + (2*CW+1)'(s1_py_reg[1]);
            s2_sy_reg[1] <= (2*CW+1)'(s1_py_reg[2]) + (2*CW+1)'(s1_py_reg[3]);
            s2_last_reg  <= s1_last_reg;
            s2_end_reg   <= s1_end_reg;

            m_tdata_reg <= {round_sat(sum_y), round_sat(sum_x)};
            m_tlast_reg <= s2_last_reg;
            m_tuser_reg <= s2_end_reg;
        end
    end

endmodule

/* rtl/catmull_rom_path_smoother.sv */
// ----------------------------------------------------------------------------
// catmull_rom_path_smoother
// smooths an open path of q12.4 control points into catmull-rom samples
// ----------------------------------------------------------------------------
// Control points enter one item at a time; s_tlast marks the last point of a
// path and s_tuser carries the explicit smooth setting. The front end takes
// no new point until each segment command of the last one (none to three)
// is in the queue. The sample engine gives SAMPLES_PER_SEGMENT samples for a
// curved segment and one for a straight segment or the end point, one result
// per cycle when the output is not stalled, so a smooth path gives about
// SAMPLES_PER_SEGMENT samples per point. Each command waits in cur_reg and
// its samples pass the s0, s1 and s2 stages and then the output register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module catmull_rom_path_smoother #(
    parameter int SAMPLES_PER_SEGMENT = 20
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // point_x, point_y
    input  logic [1:0]  s_tuser,   // has_flag, smooth_flag
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // out_x, out_y
    output logic [0:0]  m_tuser,   // path_end
    output logic        m_tlast
);

    logic           f_valid;
    logic           f_ready;
    crps_pkg::cmd_t f_data;
    logic           q_valid;
    logic           q_ready;
    crps_pkg::cmd_t q_data;

    crps_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .cmd_valid (f_valid),
        .cmd_ready (f_ready),
        .cmd_data  (f_data)
    );

    crps_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   (f_data),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_data)
    );

    crps_back #(
        .SAMPLES (SAMPLES_PER_SEGMENT)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd_data  (q_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    // the closing point is always the final result of its item
    `ASSERT_IMPLY(a_end_is_last, aclk, aresetn, m_tvalid && m_tuser[0], m_tlast)
    // a last point always leaves at least its end point command pending
    `ASSERT_NEXT(a_last_queues_cmd, aclk, aresetn, s_tvalid && s_tready && s_tlast, f_valid)
    // reset empties the output stage
    `ASSERT_NEXT(a_reset_clears_out, aclk, 1'b1, !aresetn, !m_tvalid)

endmodule

/* tb/tb_catmull_rom_path_smoother.sv */
// ----------------------------------------------------------------------------
// tb_catmull_rom_path_smoother
// self-checking bench for the catmull-rom path smoother: directed paths for
// single points, short paths, flag handling and saturation, then random open
// paths under random idling on both streams, one long output hold and paths
// with no idling, each result checked against an in-bench sample predictor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_catmull_rom_path_smoother;

    localparam int N_SAMPLES  = 20;
    localparam int MAX_CYCLES = 2_000_000;
    localparam int DRAIN_WAIT = 200;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic        run_last;
        logic        path_end;
    } smp_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;   // point_x, point_y
    logic [1:0]  s_tuser  = '0;   // has_flag, smooth_flag
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;         // out_x, out_y
    logic [0:0]  m_tuser;         // path_end
    logic        m_tlast;

    crps_pkg::wpt_t ctrl_win [3];
    int   pts_seen;
    smp_t step_out [$];
    smp_t exp_samples [$];

    int   mismatch_count = 0;
    int   results_checked = 0;
    int   items_sent = 0;
    int   paths_done = 0;
    int   curved_segs = 0;
    int   straight_segs = 0;
    int   cycle_count = 0;
    int   long_hold = 0;
    int   holds_done = 0;
    bit   src_idle_on = 1'b1;
    bit   sink_idle_on = 1'b1;

    catmull_rom_path_smoother #(
        .SAMPLES_PER_SEGMENT(N_SAMPLES)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > MAX_CYCLES) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, exp_samples.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // sample predictor
    // ------------------------------------------------------------------

    // q2.14 blend weight j at sample k, rounded half up
    function automatic longint cr_weight(int j, int k);
        longint n, n2, n3, kk, k2, k3, num, den;
        n   = N_SAMPLES;
        n2  = n * n;
        n3  = n2 * n;
        kk  = k;
        k2  = kk * kk;
        k3  = k2 * kk;
        den = 2 * n3;
        case (j)
            0:       num = -kk * n2 + 2 * k2 * n - k3;
            1:       num = 2 * n3 - 5 * k2 * n + 3 * k3;
            2:       num = kk * n2 + 4 * k2 * n - 3 * k3;
            default: num = -k2 * n + k3;
        endcase
        return (num * 16384 + n3 + 4 * 16384 * den) / den - 4 * 16384;
    endfunction

    function automatic logic [15:0] round_q4(longint s);
        longint r;
        r = (s + 8192) >>> 14;
        if (r > 32767)
            r = 32767;
        if (r < -32768)
            r = -32768;
        return 16'(r);
    endfunction

    function automatic smp_t make_sample(logic [15:0] x, logic [15:0] y, logic pend);
        smp_t s;
        s.x        = x;
        s.y        = y;
        s.run_last = 1'b0;
        s.path_end = pend;
        return s;
    endfunction

    function automatic void step_add(smp_t s);
        step_out = {step_out, s};
    endfunction

    function automatic void add_segment(crps_pkg::wpt_t a, crps_pkg::wpt_t b,
                                        crps_pkg::wpt_t c, crps_pkg::wpt_t d);
        bit     curved;
        longint w0, w1, w2, w3, sx, sy;
        if (b.has)
            curved = b.smooth;
        else
            curved = (b.pos.x != c.pos.x) && (b.pos.y != c.pos.y);
        if (!curved) begin
            straight_segs++;
            step_add(make_sample(b.pos.x, b.pos.y, 1'b0));
            return;
        end
        curved_segs++;
        for (int k = 0; k < N_SAMPLES; k++) begin
            w0 = cr_weight(0, k);
            w1 = cr_weight(1, k);
            w2 = cr_weight(2, k);
            w3 = cr_weight(3, k);
            sx = w0 * longint'(a.pos.x) + w1 * longint'(b.pos.x)
               + w2 * longint'(c.pos.x) + w3 * longint'(d.pos.x);
            sy = w0 * longint'(a.pos.y) + w1 * longint'(b.pos.y)
               + w2 * longint'(c.pos.y) + w3 * longint'(d.pos.y);
            step_add(make_sample(round_q4(sx), round_q4(sy), 1'b0));
        end
    endfunction

    function automatic void predict_point(crps_pkg::wpt_t cur, bit last);
        step_out.delete();
        if (pts_seen >= 2)
            add_segment(pts_seen >= 3 ? ctrl_win[2] : ctrl_win[1],
                        ctrl_win[1], ctrl_win[0], cur);
        if (last) begin
            if (pts_seen >= 1)
                add_segment(pts_seen >= 2 ? ctrl_win[1] : ctrl_win[0],
                            ctrl_win[0], cur, cur);
            step_add(make_sample(cur.pos.x, cur.pos.y, 1'b1));
            foreach (ctrl_win[i])
                ctrl_win[i] = '0;
            pts_seen = 0;
            paths_done++;
        end else begin
            ctrl_win[2] = ctrl_win[1];
            ctrl_win[1] = ctrl_win[0];
            ctrl_win[0] = cur;
            if (pts_seen < 3)
                pts_seen++;
        end
        if (step_out.size() > 0)
            step_out[step_out.size()-1].run_last = 1'b1;
        foreach (step_out[i])
            exp_samples = {exp_samples, step_out[i]};
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic crps_pkg::wpt_t mk_pt(int x, int y, bit has, bit smooth);
        crps_pkg::wpt_t p;
        p.pos.x  = 16'(x);
        p.pos.y  = 16'(y);
        p.has    = has;
        p.smooth = smooth;
        return p;
    endfunction

    task automatic send_point(crps_pkg::wpt_t p, bit last);
        int gap;
        gap = src_idle_on ? idle_len() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {p.pos.y, p.pos.x};
        s_tuser  <= {p.smooth, p.has};
        s_tlast  <= last;
        do
            @(posedge aclk);
        while (!s_tready);
        predict_point(p, last);
        items_sent++;
    endtask

    task automatic send_random_path(int len);
        int x, y, mode;
        bit wide;
        wide = ($urandom_range(0, 3) == 0);
        if (wide) begin
            x = $signed(16'($urandom));
            y = $signed(16'($urandom));
        end else begin
            x = int'($urandom_range(0, 4000)) - 2000;
            y = int'($urandom_range(0, 4000)) - 2000;
        end
        for (int i = 0; i < len; i++) begin
            send_point(mk_pt(x, y, $urandom_range(0, 3) == 0, 1'($urandom_range(0, 1))),
                       i == len - 1);
            mode = $urandom_range(0, 9);
            if (mode != 0 && mode != 4)
                x = wide ? $signed(16'($urandom)) : x + int'($urandom_range(0, 1200)) - 600;
            if (mode != 2 && mode != 4)
                y = wide ? $signed(16'($urandom)) : y + int'($urandom_range(0, 1200)) - 600;
        end
    endtask

    task automatic report_mismatch(string what, int want, int got);
        $display("mismatch on result %0d: %s expected %0d got %0d",
                 results_checked, what, want, got);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------

    initial begin : sink
        int stall;
        stall = 0;
        forever begin
            @(posedge aclk);
            if (long_hold > 0) begin
                stall = long_hold;
                long_hold = 0;
                holds_done++;
            end else if (stall == 0 && sink_idle_on) begin
                stall = idle_len();
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                stall--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        smp_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (exp_samples.size() == 0) begin
                report_mismatch("unexpected result, x", 0, $signed(m_tdata[15:0]));
            end else begin
                want = exp_samples.pop_front();
                if (m_tdata[15:0] !== want.x)
                    report_mismatch("out_x", $signed(want.x), $signed(m_tdata[15:0]));
                if (m_tdata[31:16] !== want.y)
                    report_mismatch("out_y", $signed(want.y), $signed(m_tdata[31:16]));
                if (m_tlast !== want.run_last)
                    report_mismatch("last_of_run", want.run_last, m_tlast);
                if (m_tuser[0] !== want.path_end)
                    report_mismatch("path_end", want.path_end, m_tuser[0]);
            end
            results_checked++;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    task automatic test_single_point();
        send_point(mk_pt(-32768, 32767, 1'b1, 1'b1), 1'b1);
        send_point(mk_pt(32767, -32768, 1'b0, 1'b1), 1'b1);
    endtask

    task automatic test_two_point_path();
        send_point(mk_pt(0, 0, 1'b0, 1'b0), 1'b0);
        send_point(mk_pt(160, 80, 1'b0, 1'b0), 1'b1);
        send_point(mk_pt(100, 100, 1'b1, 1'b0), 1'b0);
        send_point(mk_pt(200, 300, 1'b0, 1'b1), 1'b1);
    endtask

    task automatic test_flag_cases();
        // forced curve on an axis move, ignored flag, forced straight diagonal
        send_point(mk_pt(0, 0, 1'b0, 1'b0), 1'b0);
        send_point(mk_pt(0, 320, 1'b1, 1'b1), 1'b0);
        send_point(mk_pt(0, 640, 1'b0, 1'b1), 1'b0);
        send_point(mk_pt(0, 960, 1'b1, 1'b0), 1'b0);
        send_point(mk_pt(480, 1280, 1'b0, 1'b0), 1'b0);
        send_point(mk_pt(800, 1600, 1'b0, 1'b0), 1'b1);
    endtask

    task automatic test_saturation();
        send_point(mk_pt(-32768, -32768, 1'b0, 1'b0), 1'b0);
        send_point(mk_pt(32767, 32767, 1'b0, 1'b0), 1'b0);
        send_point(mk_pt(-32768, 32767, 1'b0, 1'b0), 1'b0);
        send_point(mk_pt(32767, -32768, 1'b0, 1'b0), 1'b0);
        send_point(mk_pt(-32768, -32768, 1'b0, 1'b0), 1'b1);
    endtask

    task automatic test_random_paths(int target);
        int stop_at, r;
        stop_at = items_sent + target;
        while (items_sent < stop_at) begin
            src_idle_on  = ($urandom_range(0, 3) != 0);
            sink_idle_on = ($urandom_range(0, 3) != 0);
            r = $urandom_range(0, 9);
            send_random_path(r == 0 ? 1 : r == 1 ? 2 : $urandom_range(3, 10));
        end
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
    endtask

    task automatic test_output_hold();
        // output held off while a smooth path keeps coming
        src_idle_on = 1'b0;
        long_hold = 500;
        for (int i = 0; i < 12; i++)
            send_point(mk_pt(i * 300, (i % 2) * 500 + i * 40, 1'b0, 1'b0), i == 11);
        src_idle_on = 1'b1;
    endtask

    task automatic test_back_to_back();
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        send_random_path(7);
        send_random_path(1);
        send_random_path(12);
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
    endtask

    initial begin
        int waited;
        foreach (ctrl_win[i])
            ctrl_win[i] = '0;
        pts_seen = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        test_single_point();
        test_two_point_path();
        test_flag_cases();
        test_saturation();
        test_random_paths(165);
        test_output_hold();
        test_back_to_back();

        @(posedge aclk);
        s_tvalid <= 1'b0;
        while (exp_samples.size() != 0)
            @(posedge aclk);
        waited = 0;
        while (waited < DRAIN_WAIT) begin
            @(posedge aclk);
            waited++;
        end
        if (exp_samples.size() != 0)
            report_mismatch("results never delivered", 0, exp_samples.size());

        $display("sent %0d points in %0d paths, checked %0d samples", items_sent,
                 paths_done, results_checked);
        $display("segments: %0d curved, %0d straight; long output holds: %0d",
                 curved_segs, straight_segs, holds_done);
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
